>>> rtl/tfsh_pkg.sv
// Shared types and constants for the thermal fan speed controller.
package tfsh_pkg;

  localparam int TEMP_W    = 19;
  localparam int MASK_W    = 5;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int FAN_COUNT = 5;

  // Only the low FAN_COUNT bits of the failure mask are looked at
  localparam int FAN_USED = (FAN_COUNT > MASK_W) ? MASK_W : FAN_COUNT;
  localparam logic [MASK_W-1:0] FAN_MASK = MASK_W'((1 << FAN_USED) - 1);

  // Duty levels
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_HIGH = 7'd80;
  localparam logic [PCT_W-1:0] PCT_MID  = 7'd65;
  localparam logic [PCT_W-1:0] PCT_LOW  = 7'd40;

  // Threshold reset values
  localparam logic signed [TEMP_W-1:0] RST_UP_FULL   = 19'sd57500;
  localparam logic signed [TEMP_W-1:0] RST_UP_HIGH   = 19'sd53000;
  localparam logic signed [TEMP_W-1:0] RST_UP_MID    = 19'sd49500;
  localparam logic signed [TEMP_W-1:0] RST_DOWN_HIGH = 19'sd52700;
  localparam logic signed [TEMP_W-1:0] RST_DOWN_MID  = 19'sd47700;
  localparam logic signed [TEMP_W-1:0] RST_DOWN_LOW  = 19'sd42700;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP_FULL   = 3'd0,
    REG_UP_HIGH   = 3'd1,
    REG_UP_MID    = 3'd2,
    REG_DOWN_HIGH = 3'd3,
    REG_DOWN_MID  = 3'd4,
    REG_DOWN_LOW  = 3'd5
  } cfg_idx_t;

  typedef logic signed [TEMP_W-1:0] temp_t;

  // Threshold set handed from the register file to the decision logic
  typedef struct packed {
    temp_t up_full;
    temp_t up_high;
    temp_t up_mid;
    temp_t down_high;
    temp_t down_mid;
    temp_t down_low;
  } thr_t;

  // Outcome of one transaction
  typedef struct packed {
    logic             emit;
    logic [PCT_W-1:0] percent;
    logic             forced;
    temp_t            avg;
  } dec_t;

endpackage

>>> rtl/tfsh_regs.sv
// Threshold register file, written through the configuration port.
module tfsh_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [tfsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tfsh_pkg::TEMP_W-1:0]    cfg_wdata,
  output tfsh_pkg::thr_t                 thr
);
  import tfsh_pkg::*;

  thr_t thr_r;
  thr_t thr_nxt;

  // Decode the write; indexes past the list are dropped
  always_comb begin
    thr_nxt = thr_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_UP_FULL:   thr_nxt.up_full   = temp_t'(cfg_wdata);
        REG_UP_HIGH:   thr_nxt.up_high   = temp_t'(cfg_wdata);
        REG_UP_MID:    thr_nxt.up_mid    = temp_t'(cfg_wdata);
        REG_DOWN_HIGH: thr_nxt.down_high = temp_t'(cfg_wdata);
        REG_DOWN_MID:  thr_nxt.down_mid  = temp_t'(cfg_wdata);
        REG_DOWN_LOW:  thr_nxt.down_low  = temp_t'(cfg_wdata);
        default:       thr_nxt = thr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.up_full   <= RST_UP_FULL;
      thr_r.up_high   <= RST_UP_HIGH;
      thr_r.up_mid    <= RST_UP_MID;
      thr_r.down_high <= RST_DOWN_HIGH;
      thr_r.down_mid  <= RST_DOWN_MID;
      thr_r.down_low  <= RST_DOWN_LOW;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  assign thr = thr_r;

endmodule

>>> rtl/tfsh_target.sv
// Averaging and hysteresis level selection for one transaction.
module tfsh_target (
  input  logic signed [tfsh_pkg::TEMP_W-1:0] temp_first,
  input  logic signed [tfsh_pkg::TEMP_W-1:0] temp_second,
  input  logic [tfsh_pkg::MASK_W-1:0]        fan_fail_mask,
  input  logic signed [tfsh_pkg::TEMP_W-1:0] last_temp,
  input  logic [tfsh_pkg::PCT_W-1:0]         last_percent,
  input  tfsh_pkg::thr_t                     thr,
  output tfsh_pkg::dec_t                     dec
);
  import tfsh_pkg::*;

  logic signed [TEMP_W:0] sum;
  logic signed [TEMP_W:0] sum_adj;
  temp_t                  avg;
  logic                   failed;
  logic                   same;
  logic [PCT_W-1:0]       target;

  // Average, truncated toward zero: bias odd negative sums up by one
  assign sum     = {temp_first[TEMP_W-1], temp_first} + {temp_second[TEMP_W-1], temp_second};
  assign sum_adj = sum + {{TEMP_W{1'b0}}, sum[TEMP_W] & sum[0]};
  assign avg     = temp_t'(sum_adj >>> 1);

  assign failed = |(fan_fail_mask & FAN_MASK);
  assign same   = (avg == last_temp);

  // Pick the level: full on a failed fan, else up thresholds when rising, down thresholds when not
  always_comb begin
    if (failed) begin
      target = PCT_FULL;
    end else if (avg > last_temp) begin
      if (avg >= thr.up_full)      target = PCT_FULL;
      else if (avg >= thr.up_high) target = PCT_HIGH;
      else if (avg >= thr.up_mid)  target = PCT_MID;
      else                         target = PCT_LOW;
    end else begin
      if (avg <= thr.down_low)       target = PCT_LOW;
      else if (avg <= thr.down_mid)  target = PCT_MID;
      else if (avg <= thr.down_high) target = PCT_HIGH;
      else                           target = PCT_FULL;
    end
  end

  assign dec.emit    = (failed || !same) && (target != last_percent);
  assign dec.percent = target;
  assign dec.forced  = failed;
  assign dec.avg     = avg;

endmodule

>>> rtl/thermal_fan_speed_hysteresis.sv
// Top level of the thermal fan speed controller with hysteresis.
// A transaction is held in the input register; a duty change that it causes moves on
// to the result register. Throughput: one input transaction per cycle while no change
// waits on a stalled output, set by the single decision stage between the two registers.
// Reset (rst_n low, synchronous): thresholds take their defaults, last temperature
// and last percent clear to zero, both pipeline registers empty.
module thermal_fan_speed_hysteresis (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: temp_first [18:0], temp_second [37:19], fan_fail_mask [42:38], zero pad
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [47:0]                    in_tdata,
  // out_tdata: fan_percent [6:0], zero pad [7]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,
  // out_tuser: failure_forced [0]
  output logic                           out_tuser,
  input  logic                           cfg_wr_en,
  input  logic [tfsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tfsh_pkg::TEMP_W-1:0]    cfg_wdata
);
  import tfsh_pkg::*;

  thr_t thr;
  dec_t dec;

  // Input register
  logic              s1_valid_r, s1_valid_nxt;
  temp_t             s1_first_r;
  temp_t             s1_second_r;
  logic [MASK_W-1:0] s1_mask_r;

  // Controller state
  temp_t            last_temp_r, last_temp_nxt;
  logic [PCT_W-1:0] last_pct_r, last_pct_nxt;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  logic [PCT_W-1:0] out_pct_r;
  logic             out_forced_r;

  logic out_free;
  logic s1_adv;
  logic in_fire;
  logic out_load;

  tfsh_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .thr       (thr)
  );

  tfsh_target u_target (
    .temp_first    (s1_first_r),
    .temp_second   (s1_second_r),
    .fan_fail_mask (s1_mask_r),
    .last_temp     (last_temp_r),
    .last_percent  (last_pct_r),
    .thr           (thr),
    .dec           (dec)
  );

  // Advance the input stage unless its result has nowhere to go
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!dec.emit || out_free);
  assign out_load  = s1_valid_r && dec.emit && out_free;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    last_temp_nxt = out_load ? dec.avg : last_temp_r;
    last_pct_nxt  = out_load ? dec.percent : last_pct_r;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_temp_r <= '0;
      last_pct_r  <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      last_temp_r <= last_temp_nxt;
      last_pct_r  <= last_pct_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_first_r  <= temp_t'(in_tdata[18:0]);
      s1_second_r <= temp_t'(in_tdata[37:19]);
      s1_mask_r   <= in_tdata[42:38];
    end
    if (out_load) begin
      out_pct_r    <= dec.percent;
      out_forced_r <= dec.forced;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pct_r};
  assign out_tuser  = out_forced_r;

`ifndef SYNTHESIS
  // A shown duty is always one of the four levels
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pct_r == PCT_FULL || out_pct_r == PCT_HIGH ||
                     out_pct_r == PCT_MID || out_pct_r == PCT_LOW))
    else $error("output duty is not a valid level");

  // A forced result always runs full speed
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_forced_r) |-> (out_pct_r == PCT_FULL))
    else $error("forced result below full speed");

  // Stored percent tracks the result just loaded
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (last_pct_r == out_pct_r && out_valid_r))
    else $error("stored percent out of step with result");

  // Loading a result never overwrites one still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !out_load)
    else $error("result overwritten while stalled");
`endif

endmodule

>>> dv/tfsh_duty_checker.sv
// Checker for the fan speed controller: watches all channels, predicts duty changes, compares.
`timescale 1ns / 100ps

module tfsh_duty_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [47:0]                    in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [7:0]                     out_tdata,
  input  logic                           out_tuser,
  input  logic                           cfg_wr_en,
  input  logic [tfsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tfsh_pkg::TEMP_W-1:0]    cfg_wdata,
  output int                             mismatches,
  output int                             pending
);
  import tfsh_pkg::*;

  // Only the fans that exist can force full speed
  localparam int USED_FANS = (FAN_COUNT < MASK_W) ? FAN_COUNT : MASK_W;
  localparam logic [MASK_W-1:0] LIVE_FANS = MASK_W'((1 << USED_FANS) - 1);

  typedef struct {
    logic [PCT_W-1:0] percent;
    logic             forced;
  } duty_change_t;

  duty_change_t     duty_changes[$];

  // Threshold copies, sign-extended to int
  int               thr_up_full;
  int               thr_up_high;
  int               thr_up_mid;
  int               thr_down_high;
  int               thr_down_mid;
  int               thr_down_low;

  // Hysteresis state
  int               last_avg;
  logic [PCT_W-1:0] last_duty;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: duty mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Work out the duty change, if any, caused by one input transaction
  function automatic void step_fan_control(input logic [47:0] word);
    temp_t            first;
    temp_t            second;
    logic [MASK_W-1:0] mask;
    int               avg;
    logic             failed;
    logic [PCT_W-1:0] target;
    duty_change_t     change;
    first  = word[TEMP_W-1:0];
    second = word[2*TEMP_W-1:TEMP_W];
    mask   = word[2*TEMP_W +: MASK_W];
    // Integer division truncates toward zero
    avg    = (int'(first) + int'(second)) / 2;
    failed = |(mask & LIVE_FANS);
    if (failed) begin
      target = PCT_FULL;
    end else if (avg == last_avg) begin
      return;
    end else if (avg > last_avg) begin
      if (avg >= thr_up_full)      target = PCT_FULL;
      else if (avg >= thr_up_high) target = PCT_HIGH;
      else if (avg >= thr_up_mid)  target = PCT_MID;
      else                         target = PCT_LOW;
    end else begin
      if (avg <= thr_down_low)       target = PCT_LOW;
      else if (avg <= thr_down_mid)  target = PCT_MID;
      else if (avg <= thr_down_high) target = PCT_HIGH;
      else                           target = PCT_FULL;
    end
    if (target == last_duty) return;
    last_duty      = target;
    last_avg       = avg;
    change.percent = target;
    change.forced  = failed;
    duty_changes.push_back(change);
  endfunction

  // Compare one result transaction with the oldest predicted change
  task automatic check_duty_change();
    duty_change_t want;
    if (duty_changes.size() == 0) begin
      report_mismatch($sformatf("unexpected result, percent %0d forced %0b",
                                out_tdata[PCT_W-1:0], out_tuser));
    end else begin
      want = duty_changes.pop_front();
      if (out_tdata !== {1'b0, want.percent})
        report_mismatch($sformatf("tdata 0x%02h, want percent %0d",
                                  out_tdata, want.percent));
      if (out_tuser !== want.forced)
        report_mismatch($sformatf("failure_forced %0b, want %0b", out_tuser, want.forced));
    end
  endtask

  // Sample every channel at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      thr_up_full   = int'(RST_UP_FULL);
      thr_up_high   = int'(RST_UP_HIGH);
      thr_up_mid    = int'(RST_UP_MID);
      thr_down_high = int'(RST_DOWN_HIGH);
      thr_down_mid  = int'(RST_DOWN_MID);
      thr_down_low  = int'(RST_DOWN_LOW);
      last_avg      = 0;
      last_duty     = '0;
      duty_changes.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_UP_FULL:   thr_up_full   = int'($signed(cfg_wdata));
          REG_UP_HIGH:   thr_up_high   = int'($signed(cfg_wdata));
          REG_UP_MID:    thr_up_mid    = int'($signed(cfg_wdata));
          REG_DOWN_HIGH: thr_down_high = int'($signed(cfg_wdata));
          REG_DOWN_MID:  thr_down_mid  = int'($signed(cfg_wdata));
          REG_DOWN_LOW:  thr_down_low  = int'($signed(cfg_wdata));
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_duty_change();
      if (in_tvalid && in_tready) step_fan_control(in_tdata);
    end
    pending = duty_changes.size();
  end

endmodule

>>> dv/tb_top.sv
// Testbench top for the fan speed controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import tfsh_pkg::*;

  // Indexes past the last register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int TEMP_MAX = (1 << (TEMP_W - 1)) - 1;
  localparam int TEMP_MIN = -(1 << (TEMP_W - 1));
  localparam int SPEC_LO  = -40000;
  localparam int SPEC_HI  = 150000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  // in_tdata: temp_first [18:0], temp_second [37:19], fan_fail_mask [42:38], zero pad
  logic [47:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // out_tdata: fan_percent [6:0], zero pad [7]
  logic [7:0]           out_tdata;
  // out_tuser: failure_forced [0]
  logic                 out_tuser;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TEMP_W-1:0]    cfg_wdata;

  int                   mismatches;
  int                   pending;

  // Stimulus state
  bit                   steady;
  int                   thr_now[6];
  int                   walk_temp;
  int                   prev_first;
  int                   prev_second;

  thermal_fan_speed_hysteresis dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  tfsh_duty_checker duty_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stall the result side at random, except during the steady stretch
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 21);
  end

  // Offer one reading after a random gap, hold it until accepted
  task automatic send_reading(input int first, input int second, input logic [MASK_W-1:0] mask);
    while (!steady && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= {5'b0, mask, TEMP_W'(second), TEMP_W'(first)};
    prev_first  = first;
    prev_second = second;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= TEMP_W'(value);
    if (idx <= REG_DOWN_LOW) thr_now[idx] = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, wait for every predicted change, then let the pipeline empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly a slow walk and hovering around thresholds, plus noise
  task automatic random_reading();
    int               kind;
    int               spread;
    int               first;
    int               second;
    logic [MASK_W-1:0] mask;
    kind = $urandom_range(99);
    mask = ($urandom_range(99) < 10) ? MASK_W'($urandom_range(1, 31)) : '0;
    if (kind < 60) begin
      walk_temp += int'($urandom_range(0, 8000)) - 4000;
      if (walk_temp < SPEC_LO) walk_temp = SPEC_LO;
      if (walk_temp > SPEC_HI) walk_temp = SPEC_HI;
      spread = $urandom_range(0, 600);
      first  = walk_temp + spread;
      second = walk_temp - spread + int'($urandom_range(0, 1));
    end else if (kind < 78) begin
      walk_temp = thr_now[$urandom_range(5)] + int'($urandom_range(0, 4)) - 2;
      first     = walk_temp;
      second    = walk_temp + int'($urandom_range(0, 1));
    end else if (kind < 88) begin
      first  = int'($urandom_range(0, SPEC_HI - SPEC_LO)) + SPEC_LO;
      second = int'($urandom_range(0, SPEC_HI - SPEC_LO)) + SPEC_LO;
    end else if (kind < 95) begin
      first  = int'($urandom());
      second = int'($urandom());
      mask   = MASK_W'($urandom());
    end else begin
      // Same readings again: equal average
      first  = prev_first;
      second = prev_second;
    end
    send_reading(first, second, mask);
  endtask

  task automatic random_phase(input int count);
    repeat (count) random_reading();
  endtask

  function automatic int spec_temp();
    return int'($urandom_range(0, SPEC_HI - SPEC_LO)) + SPEC_LO;
  endfunction

  initial begin
    int a;
    int b;
    int c;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    rst_n       = 1'b0;
    steady      = 1'b0;
    thr_now     = '{57500, 53000, 49500, 52700, 47700, 42700};
    walk_temp   = 45000;
    prev_first  = 0;
    prev_second = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: first item with zero average, truncation toward zero
    send_reading(0, 0, '0);
    send_reading(1, 0, '0);
    send_reading(-1, 0, '0);
    // Rise through every up threshold
    send_reading(45001, 44999, '0);
    send_reading(49500, 49501, '0);
    send_reading(53000, 53000, '0);
    send_reading(57500, 57501, '0);
    // Fall: inside the hysteresis band, then through every down threshold
    send_reading(53001, 53000, '0);
    send_reading(52700, 52701, '0);
    send_reading(47700, 47700, '0);
    send_reading(42700, 42701, '0);
    send_reading(42700, 42701, '0);
    // Failed fans, then a failure while already at full speed
    send_reading(42000, 42000, 5'b10000);
    send_reading(30000, 30000, 5'b00001);
    send_reading(42700, 42700, '0);
    // Field extremes
    send_reading(TEMP_MIN, TEMP_MIN, '0);
    send_reading(TEMP_MAX, TEMP_MAX, '0);
    send_reading(TEMP_MAX, TEMP_MIN, '0);
    send_reading(SPEC_LO, SPEC_HI, 5'b11111);
    send_reading(SPEC_HI, SPEC_HI, '0);
    send_reading(SPEC_LO, SPEC_LO, '0);
    drain();

    // Writes past the register file must change nothing
    write_threshold(REG_SPARE_LO, TEMP_MIN);
    write_threshold(REG_SPARE_HI, TEMP_MAX);
    random_phase(90);
    drain();

    // Extremes: up thresholds at the top, down thresholds at the bottom
    write_threshold(REG_UP_FULL, TEMP_MAX);
    write_threshold(REG_UP_HIGH, TEMP_MAX);
    write_threshold(REG_UP_MID, TEMP_MAX);
    write_threshold(REG_DOWN_HIGH, TEMP_MIN);
    write_threshold(REG_DOWN_MID, TEMP_MIN);
    write_threshold(REG_DOWN_LOW, TEMP_MIN);
    random_phase(90);
    drain();

    // Unordered thresholds, no idling on either side
    write_threshold(REG_UP_FULL, spec_temp());
    write_threshold(REG_UP_HIGH, spec_temp());
    write_threshold(REG_UP_MID, spec_temp());
    write_threshold(REG_DOWN_HIGH, spec_temp());
    write_threshold(REG_DOWN_MID, spec_temp());
    write_threshold(REG_DOWN_LOW, spec_temp());
    steady = 1'b1;
    random_phase(90);
    drain();
    steady = 1'b0;

    // Ordered random thresholds with a hysteresis band
    a = int'($urandom_range(0, 60000)) + 20000;
    b = a + int'($urandom_range(500, 8000));
    c = b + int'($urandom_range(500, 8000));
    write_threshold(REG_UP_MID, a);
    write_threshold(REG_UP_HIGH, b);
    write_threshold(REG_UP_FULL, c);
    write_threshold(REG_DOWN_LOW, a - int'($urandom_range(100, 3000)));
    write_threshold(REG_DOWN_MID, b - int'($urandom_range(100, 3000)));
    write_threshold(REG_DOWN_HIGH, c - int'($urandom_range(100, 3000)));
    random_phase(90);
    drain();

    // Opposite extremes: up thresholds at the bottom, down at the top
    write_threshold(REG_UP_FULL, TEMP_MIN);
    write_threshold(REG_UP_HIGH, TEMP_MIN);
    write_threshold(REG_UP_MID, TEMP_MIN);
    write_threshold(REG_DOWN_HIGH, TEMP_MAX);
    write_threshold(REG_DOWN_MID, TEMP_MAX);
    write_threshold(REG_DOWN_LOW, TEMP_MAX);
    random_phase(90);
    drain();

    if (mismatches == 0) begin
      $display("[thermal_fan_speed_hysteresis] OK");
    end else begin
      $display("[thermal_fan_speed_hysteresis] ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #2ms;
    $display("[thermal_fan_speed_hysteresis] ERROR");
    $finish;
  end

endmodule
